// File: sv/arp_icmp_echo_responder_assert.svh
// Assertion macros shared by the checker of the ARP/ICMP echo responder.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ARP_ICMP_ECHO_RESPONDER_ASSERT_SVH
`define ARP_ICMP_ECHO_RESPONDER_ASSERT_SVH

// Assertion that is switched off while reset is asserted.
`define ARPIE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked during reset.
`define ARPIE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/arpie_pkg.sv
// Package of the ARP/ICMP echo responder: payload types, queue entry, constants
// and byte-select helpers. Depends on nothing.
package arpie_pkg;

    // One received byte of the frame.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    // One byte of the reply frame.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       keep;
    } t_out_item;

    // Kind of frame, decided from the ethertype.
    typedef enum logic [1:0] {
        KIND_UNKNOWN = 2'd0,
        KIND_ARP     = 2'd1,
        KIND_IPV4    = 2'd2
    } t_kind;

    // What a queue entry expands to on the output side.
    typedef enum logic [1:0] {
        ENT_ONE = 2'd0,   // one byte: b0
        ENT_TWO = 2'd1,   // two bytes: b0 then b1
        ENT_HDR = 2'd2    // twelve bytes: peer MAC then own MAC
    } t_ent_type;

    // Queue entry between the front and the back.
    typedef struct packed {
        t_ent_type   typ;
        logic [47:0] mac;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic        last;
        logic        keep;
    } t_entry;

    // Queue status seen by both sides.
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // Configuration register indexes.
    localparam logic CFG_OWN_MAC = 1'b0;
    localparam logic CFG_OWN_IP  = 1'b1;

    // Address after reset: 192.168.1.254.
    localparam logic [31:0] OWN_IP_RESET = {8'd192, 8'd168, 8'd1, 8'd254};

    // Checksum increment for an echo request turning into an echo reply.
    localparam logic [15:0] ICMP_INC = 16'hf7ff;

    // Byte of a MAC address, first transmitted byte at index 0.
    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0: r = mac[47:40];
            3'd1: r = mac[39:32];
            3'd2: r = mac[31:24];
            3'd3: r = mac[23:16];
            3'd4: r = mac[15:8];
            3'd5: r = mac[7:0];
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Byte of an IPv4 address, first transmitted byte at index 0.
    function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0: r = ip[31:24];
            2'd1: r = ip[23:16];
            2'd2: r = ip[15:8];
            default: r = ip[7:0];
        endcase
        return r;
    endfunction

    // Fixed part of an ARP request: hardware type, protocol, lengths, opcode.
    function automatic logic [7:0] arp_fixed(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0: r = 8'h00;
            3'd1: r = 8'h01;
            3'd2: r = 8'h08;
            3'd3: r = 8'h00;
            3'd4: r = 8'h06;
            3'd5: r = 8'h04;
            3'd6: r = 8'h00;
            default: r = 8'h01;
        endcase
        return r;
    endfunction

    // Incremental ICMP checksum update for the type change from 8 to 0.
    function automatic logic [15:0] icmp_patch(input logic [7:0] hi, input logic [7:0] lo);
        logic [15:0] c;
        logic [16:0] s;
        logic [16:0] f;
        logic [15:0] r;
        c = ~{hi, lo};
        s = {1'b0, c} + {1'b0, ICMP_INC};
        f = {1'b0, s[15:0]} + {16'b0, s[16]};
        r = f[15:0] + {15'b0, f[16]};
        return ~r;
    endfunction

endpackage

// File: sv/arpie_fifo.sv
// Short queue of rewrite entries between the front and the back.
// Depends on arpie_pkg for the entry and status types.
module arpie_fifo #(
    parameter int ADDR_W = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  arpie_pkg::t_entry   i_wdata,
    input  logic                i_pop,
    output arpie_pkg::t_entry   o_rdata,
    output arpie_pkg::t_q_status o_status
);
    import arpie_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    t_entry            r_mem [DEPTH];
    logic [ADDR_W:0]   r_wr;
    logic [ADDR_W:0]   r_rd;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr[ADDR_W-1:0]] <= i_wdata;
        end
    end

    // Write and read pointers, one extra bit to tell full from empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    // Head entry and status.
    assign o_rdata        = r_mem[r_rd[ADDR_W-1:0]];
    assign o_status.empty = (r_wr == r_rd);
    assign o_status.full  = (r_wr[ADDR_W] != r_rd[ADDR_W]) &&
                            (r_wr[ADDR_W-1:0] == r_rd[ADDR_W-1:0]);

endmodule

// File: sv/arpie_front.sv
// Front of the responder: accepts received bytes, tracks the frame and its
// checks, and queues rewrite entries. Depends on arpie_pkg.
module arpie_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  arpie_pkg::t_in_item  i_data,
    input  logic [47:0]          i_own_mac,
    input  logic [31:0]          i_own_ip,
    input  arpie_pkg::t_q_status i_q,
    output logic                 o_push,
    output arpie_pkg::t_entry    o_entry
);
    import arpie_pkg::*;

    // Byte positions within the frame.
    localparam logic [5:0] POS_SRC_MAC  = 6'd6;
    localparam logic [5:0] POS_HDR_END  = 6'd11;
    localparam logic [5:0] POS_TYPE_HI  = 6'd12;
    localparam logic [5:0] POS_TYPE_LO  = 6'd13;
    localparam logic [5:0] POS_L3       = 6'd14;
    localparam logic [5:0] POS_ARP_SHA  = 6'd22;
    localparam logic [5:0] POS_ARP_SPA  = 6'd28;
    localparam logic [5:0] POS_ARP_TPA  = 6'd38;
    localparam logic [5:0] POS_ARP_END  = 6'd41;
    localparam logic [5:0] POS_IP_SRC   = 6'd26;
    localparam logic [5:0] POS_IP_DST   = 6'd30;
    localparam logic [5:0] POS_ICMP_CS  = 6'd37;
    localparam logic [5:0] POS_MAX      = 6'd63;

    logic [5:0]  r_pos, n_pos;
    logic [47:0] r_peer, n_peer;
    t_kind       r_kind, n_kind;
    logic        r_pass, n_pass;
    logic [47:0] r_arp_mac, n_arp_mac;
    logic [31:0] r_sip, n_sip;
    logic        r_tmm, n_tmm;
    logic        r_tim, n_tim;
    logic [7:0]  r_held, n_held;
    logic        r_closed, n_closed;

    logic        accept;
    logic        emit;
    logic        keep_v;
    logic [7:0]  b;
    logic [5:0]  rel;
    logic [15:0] csum;
    t_entry      ent;

    assign accept  = i_valid && !i_q.full;
    assign o_stall = i_q.full;
    assign b       = i_data.in_byte;
    assign csum    = icmp_patch(r_held, b);

    // Per-byte classification, checks and entry generation.
    always_comb begin
        n_pos     = r_pos;
        n_peer    = r_peer;
        n_kind    = r_kind;
        n_pass    = r_pass;
        n_arp_mac = r_arp_mac;
        n_sip     = r_sip;
        n_tmm     = r_tmm;
        n_tim     = r_tim;
        n_held    = r_held;
        n_closed  = r_closed;
        emit      = 1'b0;
        keep_v    = 1'b0;
        rel       = '0;
        ent.typ   = ENT_ONE;
        ent.mac   = '0;
        ent.b0    = b;
        ent.b1    = '0;
        ent.last  = 1'b0;
        ent.keep  = 1'b0;

        if (!r_closed) begin
            if (r_pos < POS_SRC_MAC) begin
                // Destination MAC gives nothing.
                emit = 1'b0;
            end else if (r_pos <= POS_HDR_END) begin
                // Source MAC becomes the reply destination; the header goes out at once.
                n_peer = {r_peer[39:0], b};
                if (r_pos == POS_SRC_MAC && b[0]) begin
                    n_pass = 1'b0;
                end
                if (r_pos == POS_HDR_END) begin
                    emit    = 1'b1;
                    ent.typ = ENT_HDR;
                    ent.mac = n_peer;
                end
            end else if (r_pos == POS_TYPE_HI) begin
                n_held = b;
                emit   = 1'b1;
            end else if (r_pos == POS_TYPE_LO) begin
                if (r_held == 8'h08 && b == 8'h06) begin
                    n_kind = KIND_ARP;
                end else if (r_held == 8'h08 && b == 8'h00) begin
                    n_kind = KIND_IPV4;
                end else begin
                    n_kind = KIND_UNKNOWN;
                end
                emit = 1'b1;
            end else begin
                case (r_kind)
                    KIND_ARP: begin
                        emit = 1'b1;
                        if (r_pos < POS_ARP_SHA) begin
                            // Fixed fields; the opcode turns into a reply.
                            rel = r_pos - POS_L3;
                            if (b != arp_fixed(rel[2:0])) begin
                                n_pass = 1'b0;
                            end
                            if (r_pos == POS_ARP_SHA - 6'd1) begin
                                ent.b0 = 8'h02;
                            end
                        end else if (r_pos < POS_ARP_SPA) begin
                            // Sender MAC is stored; own MAC goes out.
                            rel       = r_pos - POS_ARP_SHA;
                            n_arp_mac = {r_arp_mac[39:0], b};
                            if (r_pos == POS_ARP_SHA && b[0]) begin
                                n_pass = 1'b0;
                            end
                            ent.b0 = mac_byte(i_own_mac, rel[2:0]);
                        end else if (r_pos < POS_ARP_SPA + 6'd4) begin
                            // Sender IP is stored; own IP goes out.
                            rel   = r_pos - POS_ARP_SPA;
                            n_sip = {r_sip[23:0], b};
                            if (r_pos == POS_ARP_SPA + 6'd3 && n_sip == 32'hffffffff) begin
                                n_pass = 1'b0;
                            end
                            ent.b0 = ip_byte(i_own_ip, rel[1:0]);
                        end else if (r_pos < POS_ARP_TPA) begin
                            // Target MAC is compared; sender MAC goes out.
                            rel = r_pos - (POS_ARP_SPA + 6'd4);
                            if (b != mac_byte(i_own_mac, rel[2:0])) begin
                                n_tmm = 1'b0;
                            end
                            ent.b0 = mac_byte(r_arp_mac, rel[2:0]);
                        end else begin
                            // Target IP is compared; sender IP goes out.
                            rel = r_pos - POS_ARP_TPA;
                            if (b != ip_byte(i_own_ip, rel[1:0])) begin
                                n_tim = 1'b0;
                            end
                            ent.b0 = ip_byte(r_sip, rel[1:0]);
                        end
                    end
                    KIND_IPV4: begin
                        emit = 1'b1;
                        if (r_pos == POS_L3 && b[3:0] != 4'd5) begin
                            n_pass = 1'b0;
                        end
                        if ((r_pos == 6'd20 && b[5:0] != 6'd0) || (r_pos == 6'd21 && b != 8'd0)) begin
                            n_pass = 1'b0;
                        end
                        if ((r_pos == 6'd22 && b == 8'd0) || (r_pos == 6'd23 && b != 8'd1)) begin
                            n_pass = 1'b0;
                        end
                        if (r_pos >= POS_IP_SRC && r_pos < POS_IP_DST) begin
                            // Source address is stored; own IP goes out.
                            rel   = r_pos - POS_IP_SRC;
                            n_sip = {r_sip[23:0], b};
                            if (r_pos == POS_IP_DST - 6'd1 && n_sip == 32'd0) begin
                                n_pass = 1'b0;
                            end
                            ent.b0 = ip_byte(i_own_ip, rel[1:0]);
                        end else if (r_pos >= POS_IP_DST && r_pos < POS_IP_DST + 6'd4) begin
                            // Destination is compared; stored source goes out.
                            rel = r_pos - POS_IP_DST;
                            if (b != ip_byte(i_own_ip, rel[1:0])) begin
                                n_tim = 1'b0;
                            end
                            ent.b0 = ip_byte(r_sip, rel[1:0]);
                        end else if (r_pos == POS_ICMP_CS - 6'd3) begin
                            // Echo request type becomes echo reply.
                            if (b != 8'd8) begin
                                n_pass = 1'b0;
                            end
                            ent.b0 = 8'h00;
                        end else if (r_pos == POS_ICMP_CS - 6'd2) begin
                            if (b != 8'd0) begin
                                n_pass = 1'b0;
                            end
                        end else if (r_pos == POS_ICMP_CS - 6'd1) begin
                            // Checksum high byte is held until the low byte arrives.
                            n_held = b;
                            emit   = 1'b0;
                        end else if (r_pos == POS_ICMP_CS) begin
                            ent.typ = ENT_TWO;
                            ent.b0  = csum[15:8];
                            ent.b1  = csum[7:0];
                        end
                    end
                    default: begin
                        emit = 1'b1;
                    end
                endcase
            end

            // Frame end or end of an ARP reply closes the reply with a verdict.
            if (i_data.in_last || (n_kind == KIND_ARP && r_pos == POS_ARP_END)) begin
                case (n_kind)
                    KIND_ARP:  keep_v = (r_pos == POS_ARP_END) && n_pass && (n_tmm || n_tim);
                    KIND_IPV4: keep_v = (r_pos >= POS_ICMP_CS) && n_pass && n_tim;
                    default:   keep_v = 1'b0;
                endcase
                if (!emit) begin
                    emit    = 1'b1;
                    ent.typ = ENT_ONE;
                    ent.b0  = 8'h00;
                    keep_v  = 1'b0;
                end
                ent.last = 1'b1;
                ent.keep = keep_v;
                n_closed = 1'b1;
            end
        end

        // Position advance, or a fresh start after the final byte.
        if (i_data.in_last) begin
            n_pos    = '0;
            n_kind   = KIND_UNKNOWN;
            n_pass   = 1'b1;
            n_tmm    = 1'b1;
            n_tim    = 1'b1;
            n_closed = 1'b0;
        end else if (r_pos < POS_MAX) begin
            n_pos = r_pos + 6'd1;
        end
    end

    assign o_push  = accept && emit;
    assign o_entry = ent;

    // Frame control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_kind   <= KIND_UNKNOWN;
            r_pass   <= 1'b1;
            r_tmm    <= 1'b1;
            r_tim    <= 1'b1;
            r_closed <= 1'b0;
        end else if (accept) begin
            r_pos    <= n_pos;
            r_kind   <= n_kind;
            r_pass   <= n_pass;
            r_tmm    <= n_tmm;
            r_tim    <= n_tim;
            r_closed <= n_closed;
        end
    end

    // Captured addresses and the held byte.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_peer    <= n_peer;
            r_arp_mac <= n_arp_mac;
            r_sip     <= n_sip;
            r_held    <= n_held;
        end
    end

endmodule

// File: sv/arpie_back.sv
// Back of the responder: expands queued entries into reply bytes and holds
// them in the output register. Depends on arpie_pkg.
module arpie_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  arpie_pkg::t_entry    i_head,
    input  arpie_pkg::t_q_status i_q,
    output logic                 o_pop,
    input  logic [47:0]          i_own_mac,
    output logic                 o_valid,
    input  logic                 i_stall,
    output arpie_pkg::t_out_item o_data
);
    import arpie_pkg::*;

    localparam logic [3:0] HDR_SPLIT = 4'd6;
    localparam logic [3:0] HDR_FINAL = 4'd11;

    logic       r_valid, n_valid;
    logic [3:0] r_idx, n_idx;
    t_out_item  r_out, n_out;

    logic       adv;
    logic       take;
    logic       fin;
    logic [3:0] fin_idx;
    logic [3:0] rel;
    logic [7:0] byte_v;

    // Byte selection within the head entry.
    always_comb begin
        rel = r_idx - HDR_SPLIT;
        case (i_head.typ)
            ENT_HDR: fin_idx = HDR_FINAL;
            ENT_TWO: fin_idx = 4'd1;
            default: fin_idx = 4'd0;
        endcase
        case (i_head.typ)
            ENT_HDR: byte_v = (r_idx < HDR_SPLIT) ? mac_byte(i_head.mac, r_idx[2:0])
                                                  : mac_byte(i_own_mac, rel[2:0]);
            ENT_TWO: byte_v = r_idx[0] ? i_head.b1 : i_head.b0;
            default: byte_v = i_head.b0;
        endcase
        fin = (r_idx == fin_idx);
    end

    // Output register loads when empty or when its transfer completes.
    always_comb begin
        adv     = !r_valid || !i_stall;
        take    = adv && !i_q.empty;
        n_valid = r_valid;
        n_idx   = r_idx;
        n_out   = r_out;
        if (adv) begin
            n_valid = !i_q.empty;
        end
        if (take) begin
            n_out.out_byte = byte_v;
            n_out.out_last = fin && i_head.last;
            n_out.keep     = fin && i_head.keep;
            n_idx          = fin ? 4'd0 : r_idx + 4'd1;
        end
    end

    assign o_pop   = take && fin;
    assign o_valid = r_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

// File: sv/arp_icmp_echo_responder.sv
// ARP and ICMP echo responder. Received Ethernet bytes enter one per cycle on
// the input channel and leave rewritten as a reply (ARP reply or ICMP echo
// reply), with out_last and a keep/discard verdict on the reply's final byte.
// An input byte is taken every cycle while the entry queue has room. An entry
// that finds the queue empty is written into it and then loaded into the output
// register once that is free. The 12-byte MAC header goes out when source MAC
// byte 11 arrives, so from then on the reply trails the input; the queue
// (2**Q_ADDR_W entries) absorbs that burst, so with a free-running output the
// input never stalls. Padding after an ARP reply and bytes 0 to 10 give no
// output. Configuration (own_mac at index 0, own_ip at index 1) is written
// by the user only while no frame is in flight; the block does not enforce it.
// Depends on arpie_pkg, arpie_front, arpie_fifo and arpie_back.
module arp_icmp_echo_responder #(
    parameter int Q_ADDR_W = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  arpie_pkg::t_in_item  i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output arpie_pkg::t_out_item o_data,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [47:0]          i_cfg_data
);
    import arpie_pkg::*;

    logic [47:0] r_own_mac;
    logic [31:0] r_own_ip;
    logic        push;
    logic        pop;
    t_entry      wr_ent;
    t_entry      head;
    t_q_status   q_stat;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac <= '0;
            r_own_ip  <= OWN_IP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OWN_MAC: r_own_mac <= i_cfg_data;
                CFG_OWN_IP:  r_own_ip  <= i_cfg_data[31:0];
                default:     r_own_mac <= r_own_mac;
            endcase
        end
    end

    // Front: classify and rewrite.
    arpie_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_data    (i_data),
        .i_own_mac (r_own_mac),
        .i_own_ip  (r_own_ip),
        .i_q       (q_stat),
        .o_push    (push),
        .o_entry   (wr_ent)
    );

    // Entry queue.
    arpie_fifo #(
        .ADDR_W (Q_ADDR_W)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wdata  (wr_ent),
        .i_pop    (pop),
        .o_rdata  (head),
        .o_status (q_stat)
    );

    // Back: expand entries into output bytes.
    arpie_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .i_q       (q_stat),
        .o_pop     (pop),
        .i_own_mac (r_own_mac),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data)
    );

endmodule

// File: sv/arpie_chk.sv
// Port-level checker of the ARP/ICMP echo responder and its bind.
// Depends on arpie_pkg and arp_icmp_echo_responder_assert.svh.
`include "arp_icmp_echo_responder_assert.svh"

module arpie_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input arpie_pkg::t_out_item o_data
);
    // A stalled output transfer keeps its valid.
    `ARPIE_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> o_valid, "valid dropped while stalled")

    // A stalled output transfer keeps its payload.
    `ARPIE_ASSERT(a_out_stable, i_clk, i_rst_n, (o_valid && i_stall) |=> $stable(o_data), "payload changed while stalled")

    // A verdict is only given on the final byte of a reply.
    `ARPIE_ASSERT(a_keep_last, i_clk, i_rst_n, o_valid |-> (!o_data.keep || o_data.out_last), "keep without out_last")

    // Reset empties the output register.
    `ARPIE_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")

    // Reset empties the queue, so input is taken right away.
    `ARPIE_ASSERT_ALWAYS(a_rst_in, i_clk, !i_rst_n |=> !o_stall, "input stalled after reset")

endmodule

bind arp_icmp_echo_responder arpie_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
